### design/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// shared constants and types of the masked signature scanner
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

    localparam int SIG_BYTES   = 16;
    localparam int WINDOW_BITS = SIG_BYTES * 8;
    localparam int SH_W        = $clog2(SIG_BYTES);
    localparam int LEN_W       = 5;
    localparam int COUNT_W     = 29;
    localparam int ADDR_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int CARE_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COUNT_W-1:0] REGION_LIMIT = 29'h1000_0000;

    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SIG_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIG_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE     = 3'd4;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] sig_low;
        logic [CFG_DATA_W-1:0] sig_high;
        logic [CARE_W-1:0]     care;
        logic [LEN_W-1:0]      length;
    } t_sig_cfg;

    typedef struct packed {
        logic               last;
        logic               too_long;
        logic               hit;
        logic [COUNT_W-1:0] offset;
    } t_scan_item;

endpackage

`default_nettype wire

### design/mss_front.sv
// ----------------------------------------------------------------------------
// mss_front
// byte intake: sliding window, region count and masked compare per byte
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  mss_pkg::t_sig_cfg   i_cfg,
    input  logic                i_queue_full,
    output logic                o_push,
    output mss_pkg::t_scan_item o_item
);
    import mss_pkg::*;

    logic [WINDOW_BITS-1:0] r_window;
    logic [WINDOW_BITS-1:0] n_window;
    logic [WINDOW_BITS-1:0] aligned;
    logic [WINDOW_BITS-1:0] sig;
    logic [COUNT_W-1:0]     r_seen;
    logic [COUNT_W-1:0]     n_seen;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       sh_full;
    logic [SH_W-1:0]        sh;
    logic [SIG_BYTES-1:0]   mismatch;
    logic                   accept;

    assign accept     = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;
    assign o_push     = accept;

    always_comb begin
        priority if (i_cfg.length == '0) begin
            len = LEN_W'(1);
        end else if (i_cfg.length > LEN_W'(SIG_BYTES)) begin
            len = LEN_W'(SIG_BYTES);
        end else begin
            len = i_cfg.length;
        end
    end

    assign sh_full  = LEN_W'(SIG_BYTES) - len;
    assign sh       = sh_full[SH_W-1:0];
    assign n_window = {i_data_byte, r_window[WINDOW_BITS-1:8]};
    assign aligned  = n_window >> {sh, 3'b000};
    assign sig      = {i_cfg.sig_high, i_cfg.sig_low};

    always_comb begin
        for (int i = 0; i < SIG_BYTES; i++) begin
            mismatch[i] = i_cfg.care[i] && (LEN_W'(i) < len) &&
                          (aligned[i*8 +: 8] != sig[i*8 +: 8]);
        end
    end

    assign n_seen = (r_seen <= REGION_LIMIT) ? r_seen + 1'b1 : r_seen;

    always_comb begin
        o_item.last     = i_last_byte;
        o_item.too_long = n_seen > REGION_LIMIT;
        o_item.hit      = (n_seen <= REGION_LIMIT) && (n_seen >= COUNT_W'(len)) &&
                          !(|mismatch);
        o_item.offset   = n_seen - COUNT_W'(len);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_window <= n_window;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            r_seen <= i_last_byte ? '0 : n_seen;
        end
    end

endmodule

`default_nettype wire

### design/mss_queue.sv
// ----------------------------------------------------------------------------
// mss_queue
// short queue of classified bytes between intake and result stage
// ----------------------------------------------------------------------------
`default_nettype none

module mss_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mss_pkg::t_scan_item i_item,
    output logic                o_full,
    output logic                o_valid,
    output mss_pkg::t_scan_item o_item,
    input  logic                i_pop
);
    import mss_pkg::*;

    t_scan_item          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

### design/mss_back.sv
// ----------------------------------------------------------------------------
// mss_back
// result stage: keeps the first match and forms the result per region
// ----------------------------------------------------------------------------
`default_nettype none

module mss_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  mss_pkg::t_scan_item         i_item,
    output logic                        o_pop,
    input  logic [mss_pkg::ADDR_W-1:0]  i_base,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [mss_pkg::STATUS_W-1:0] o_scan_status,
    output logic [mss_pkg::ADDR_W-1:0]  o_match_address
);
    import mss_pkg::*;

    logic                r_match_seen;
    logic [COUNT_W-1:0]  r_offset;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0]   r_addr;
    logic [STATUS_W-1:0] n_status;
    logic [ADDR_W-1:0]   n_addr;
    logic [COUNT_W-1:0]  sel_offset;
    logic                out_free;
    logic                pop;
    logic                found;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign pop        = i_q_valid && (!i_item.last || out_free);
    assign o_pop      = pop;
    assign found      = r_match_seen || i_item.hit;
    assign sel_offset = r_match_seen ? r_offset : i_item.offset;

    always_comb begin
        priority if (i_item.too_long) begin
            n_status = STATUS_TOO_LONG;
            n_addr   = '0;
        end else if (found) begin
            n_status = STATUS_FOUND;
            n_addr   = i_base + ADDR_W'(sel_offset);
        end else begin
            n_status = STATUS_NOT_FOUND;
            n_addr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                if (i_item.last) begin
                    r_match_seen <= 1'b0;
                end else if (!r_match_seen && i_item.hit) begin
                    r_match_seen <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !i_item.last && !r_match_seen && i_item.hit) begin
            r_offset <= i_item.offset;
        end
        if (pop && i_item.last) begin
            r_status <= n_status;
            r_addr   <= n_addr;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_scan_status   = r_status;
    assign o_match_address = r_addr;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == STATUS_FOUND || r_status == STATUS_NOT_FOUND ||
                         r_status == STATUS_TOO_LONG))
        else $error("undefined scan status");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != STATUS_FOUND) |-> r_addr == '0)
        else $error("address set without a match");

    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_item.last) |=> (!r_match_seen && r_out_valid))
        else $error("region state not cleared after final byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(pop && i_item.last))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### design/masked_signature_scan.sv
// ----------------------------------------------------------------------------
// masked_signature_scan
// byte stream search for a signature of up to 16 bytes with wildcard bytes
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle, steadily, for as long as the
// result side keeps up; the masked compare of the whole window against the
// signature is done in the same cycle as the byte is taken, and a
// four-entry queue separates the intake from the result register. A result
// follows a region's final byte through the queue into the result register;
// the next region may start in the cycle after that byte. Registers
// are written through the configuration channel, which is always ready, and
// must only be changed while no region is in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_signature_scan (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [mss_pkg::STATUS_W-1:0]     o_scan_status,
    output logic [mss_pkg::ADDR_W-1:0]       o_match_address,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mss_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [mss_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mss_pkg::*;

    t_sig_cfg          r_cfg;
    logic [ADDR_W-1:0] r_base;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;
    t_scan_item        front_item;
    t_scan_item        q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sig_low  <= '0;
            r_cfg.sig_high <= '0;
            r_cfg.care     <= '1;
            r_cfg.length   <= LEN_W'(1);
            r_base         <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SIG_LOW:  r_cfg.sig_low  <= i_cfg_data;
                CFG_SIG_HIGH: r_cfg.sig_high <= i_cfg_data;
                CFG_CARE:     r_cfg.care     <= i_cfg_data[CARE_W-1:0];
                CFG_LENGTH:   r_cfg.length   <= i_cfg_data[LEN_W-1:0];
                CFG_BASE:     r_base         <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    mss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg        (r_cfg),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    mss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    mss_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_item          (q_item),
        .o_pop           (pop),
        .i_base          (r_base),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_scan_status   (o_scan_status),
        .o_match_address (o_match_address)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the masked signature scanner
// ----------------------------------------------------------------------------
// Regions of bytes are queued by a stimulus process and driven in bursts with
// random gaps, while the result side stalls on a changing pattern. Every
// accepted byte is fed to a model of the scan state kept in the bench, which
// forms the expected report at the final byte of a region. Reports from the
// block are compared field by field in order. Signature, care mask, length
// and base are reprogrammed between phases, once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import mss_pkg::*;

    localparam int RANDOM_BYTES = 1600;
    localparam int QUIET_LIMIT  = 5000;
    localparam int MAX_REGION   = 300;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_TOP = '1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_region_byte;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } t_scan_report;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic [7:0]             in_data   = '0;
    logic                   in_last   = 1'b0;
    logic                   out_stall = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                   in_stall;
    logic                   out_valid;
    logic [STATUS_W-1:0]    scan_status;
    logic [ADDR_W-1:0]      match_address;
    logic                   cfg_ready;

    masked_signature_scan dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (in_data),
        .i_last_byte     (in_last),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_scan_status   (scan_status),
        .o_match_address (match_address),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // register copies
    logic [CFG_DATA_W-1:0] sig_low  = '0;
    logic [CFG_DATA_W-1:0] sig_high = '0;
    logic [CARE_W-1:0]     care     = '1;
    logic [LEN_W-1:0]      sig_len  = 5'd1;
    logic [ADDR_W-1:0]     base     = '0;

    // scan state
    logic [7:0]            win [SIG_BYTES];
    logic [COUNT_W-1:0]    seen         = '0;
    logic                  matched      = 1'b0;
    logic [COUNT_W-1:0]    first_offset = '0;

    t_region_byte region_bytes [$];
    t_scan_report scan_reports_due [$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_taken  = 0;
    int unsigned mismatches   = 0;
    int unsigned n_found      = 0;
    int unsigned n_missing    = 0;
    int unsigned n_too_long   = 0;
    int unsigned n_phases     = 0;
    int unsigned quiet        = 0;
    int unsigned gap_style    = 0;
    int unsigned gap_left     = 0;
    int unsigned burst_left   = 0;
    int unsigned stall_mode   = 0;
    int unsigned stall_tick   = 0;
    logic        in_fire      = 1'b0;

    initial begin
        for (int k = 0; k < SIG_BYTES; k++) win[k] = '0;
        forever #2 clk = ~clk;
    end

    function automatic int active_span();
        if (sig_len == 0) return 1;
        if (sig_len > SIG_BYTES) return SIG_BYTES;
        return int'(sig_len);
    endfunction

    function automatic logic [7:0] sig_byte(input int k);
        if (k < 8) return sig_low[8*k +: 8];
        return sig_high[8*(k-8) +: 8];
    endfunction

    task automatic track_byte(input logic [7:0] b, input logic last);
        int           span;
        logic         hit;
        t_scan_report rpt;
        span = active_span();
        for (int k = 0; k < SIG_BYTES - 1; k++) win[k] = win[k+1];
        win[SIG_BYTES-1] = b;
        if (seen <= REGION_LIMIT) seen = seen + 1'b1;
        if (!matched && seen <= REGION_LIMIT && seen >= span) begin
            hit = 1'b1;
            for (int k = 0; k < span; k++) begin
                if (care[k] && win[SIG_BYTES-span+k] != sig_byte(k)) hit = 1'b0;
            end
            if (hit) begin
                matched      = 1'b1;
                first_offset = seen - COUNT_W'(span);
            end
        end
        if (last) begin
            if (seen > REGION_LIMIT) begin
                rpt.status = STATUS_TOO_LONG;
                rpt.addr   = '0;
            end else if (matched) begin
                rpt.status = STATUS_FOUND;
                rpt.addr   = base + ADDR_W'(first_offset);
            end else begin
                rpt.status = STATUS_NOT_FOUND;
                rpt.addr   = '0;
            end
            scan_reports_due.insert(scan_reports_due.size(), rpt);
            for (int k = 0; k < SIG_BYTES; k++) win[k] = '0;
            seen         = '0;
            matched      = 1'b0;
            first_offset = '0;
        end
    endtask

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // input side and result checking
    always @(posedge clk) begin
        t_scan_report want;
        in_fire <= in_valid && !in_stall;
        if (in_valid && !in_stall) begin
            track_byte(in_data, in_last);
            bytes_taken++;
        end
        if (rst_n && out_valid && !out_stall) begin
            if (scan_reports_due.size() == 0) begin
                note_mismatch($sformatf("unexpected report status %0d address %h",
                                        scan_status, match_address));
            end else begin
                want = scan_reports_due.pop_front();
                if (scan_status !== want.status || match_address !== want.addr)
                    note_mismatch($sformatf("status %0d address %h, expected %0d %h",
                                            scan_status, match_address,
                                            want.status, want.addr));
                case (want.status)
                    STATUS_FOUND:     n_found++;
                    STATUS_NOT_FOUND: n_missing++;
                    default:          n_too_long++;
                endcase
            end
        end
    end

    // byte driver, bursts with gaps
    always @(negedge clk) begin
        t_region_byte nxt;
        if (!in_valid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (region_bytes.size() != 0) begin
                nxt = region_bytes.pop_front();
                in_data  <= nxt.data;
                in_last  <= nxt.last;
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    case (gap_style)
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(0, 3);
                        default: gap_left = $urandom_range(2, 12);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side stall pattern
    always @(negedge clk) begin
        stall_tick++;
        if (stall_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_tick % 4 != 0);
        endcase
    end

    // watchdog
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_SIG_LOW:  sig_low  = data;
            CFG_SIG_HIGH: sig_high = data;
            CFG_CARE:     care     = data[CARE_W-1:0];
            CFG_LENGTH:   sig_len  = data[LEN_W-1:0];
            CFG_BASE:     base     = data[ADDR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_region_byte item;
        item.data = b;
        item.last = last;
        region_bytes.insert(region_bytes.size(), item);
        bytes_queued++;
    endtask

    task automatic queue_region(input int n);
        logic [7:0] pick [MAX_REGION];
        int         span;
        int         at;
        bit         narrow;
        span   = active_span();
        narrow = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if (narrow && $urandom_range(0, 1))
                pick[i] = sig_byte($urandom_range(0, span - 1));
            else
                pick[i] = 8'($urandom);
        end
        if ($urandom_range(0, 9) < 6 && n >= span) begin
            at = ($urandom_range(0, 3) == 0) ? n - span : $urandom_range(0, n - span);
            for (int k = 0; k < span; k++)
                if (care[k]) pick[at+k] = sig_byte(k);
        end
        for (int i = 0; i < n; i++) queue_byte(pick[i], i == n - 1);
    endtask

    // wait for the block to go idle before touching registers
    task automatic drain();
        do @(negedge clk);
        while (bytes_taken != bytes_queued || scan_reports_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] word;
        int                    spare;
        int                    n;
        int                    roll;
        int unsigned           phase_end;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero signature of one byte
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b1);
        drain();

        // length zero counts as one, address wraps past the top
        write_reg(CFG_SIG_LOW, 64'hFFFF_FFFF_FFFF_FFA5);
        write_reg(CFG_LENGTH, '0);
        write_reg(CFG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_byte(8'hA5, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b1);
        drain();

        // oversized length clamps to sixteen, all positions wildcard
        write_reg(CFG_SIG_HIGH, '1);
        write_reg(CFG_CARE, '0);
        write_reg(CFG_LENGTH, 64'h1F);
        write_reg(CFG_BASE, 64'h8000_0000);
        for (int i = 0; i < SIG_BYTES; i++) queue_byte(8'($urandom), i == SIG_BYTES - 1);
        queue_byte(8'hFF, 1'b1);
        drain();

        phase_end = bytes_queued + RANDOM_BYTES;
        while (bytes_queued < phase_end) begin
            n_phases++;
            case ($urandom_range(0, 7))
                0: word = '0;
                1: word = '1;
                default: word = {$urandom, $urandom};
            endcase
            write_reg(CFG_SIG_LOW, word);
            write_reg(CFG_SIG_HIGH, ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom});
            word = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: word[CARE_W-1:0] = '1;
                1: word[CARE_W-1:0] = '0;
                2: word[CARE_W-1:0] = CARE_W'($urandom & $urandom);
                default: ;
            endcase
            write_reg(CFG_CARE, word);
            word = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0: word[LEN_W-1:0] = 5'd0;
                1: word[LEN_W-1:0] = 5'd31;
                2: word[LEN_W-1:0] = 5'd16;
                3: word[LEN_W-1:0] = 5'd1;
                4: word[LEN_W-1:0] = 5'd17;
                default: word[LEN_W-1:0] = LEN_W'($urandom_range(2, 15));
            endcase
            write_reg(CFG_LENGTH, word);
            word = {$urandom, $urandom};
            case ($urandom_range(0, 3))
                0: word[ADDR_W-1:0] = '0;
                1: word[ADDR_W-1:0] = '1;
                2: word[ADDR_W-1:0] = {24'hFF_FFFF, 8'($urandom)};
                default: ;
            endcase
            write_reg(CFG_BASE, word);
            if ($urandom_range(0, 3) == 0) begin
                spare = $urandom_range(int'(CFG_BASE) + 1, int'(CFG_SPARE_TOP));
                write_reg(CFG_INDEX_W'(spare), {$urandom, $urandom});
            end

            gap_style = $urandom_range(0, 2);
            n = bytes_queued + $urandom_range(60, 200);
            while (bytes_queued < n) begin
                roll = $urandom_range(0, 19);
                if (roll <= 12)
                    queue_region($urandom_range(1, 24));
                else if (roll <= 18)
                    queue_region($urandom_range(25, 80));
                else
                    queue_region($urandom_range(100, MAX_REGION));
            end
            drain();
        end

        repeat (10) @(posedge clk);
        $display("%0d bytes over %0d random register settings, %0d reports checked",
                 bytes_taken, n_phases, n_found + n_missing + n_too_long);
        $display("reports: %0d found, %0d not found, %0d too long",
                 n_found, n_missing, n_too_long);
        if (mismatches == 0 && scan_reports_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

### masked_signature_scan.f
design/mss_pkg.sv
design/mss_front.sv
design/mss_queue.sv
design/mss_back.sv
design/masked_signature_scan.sv
tb/tb_top.sv
